>>> hdl/nearest_timestamp_sample_history_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-timestamp sample history
// Both macros expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TIMESTAMP_SAMPLE_HISTORY_MACROS_SVH
`define NEAREST_TIMESTAMP_SAMPLE_HISTORY_MACROS_SVH

// same-cycle implication, switched off while in reset
`define NTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off while in reset
`define NTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// Beat types, stored entry layout, request codes and controller states.
// ----------------------------------------------------------------------------
package nts_pkg;

  // request codes
  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // input beat
  typedef struct packed {
    logic        req_type;
    logic [31:0] sample_time;
    logic [31:0] sample_yaw_bits;
    logic [31:0] sample_pitch_bits;
    logic [31:0] sample_payload;
    logic [31:0] query_time;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic        found;
    logic [31:0] match_time;
    logic [31:0] match_yaw_bits;
    logic [31:0] match_pitch_bits;
    logic [31:0] match_payload;
  } out_beat_t;

  // one history entry as held in the RAM
  typedef struct packed {
    logic [31:0] ts;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [31:0] payload;
  } entry_t;

  // result handshake between controller and output register
  typedef struct packed {
    logic      valid;
    out_beat_t data;
  } res_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

>>> hdl/nts_ram.sv
// ----------------------------------------------------------------------------
// nts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nts_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/nts_ctrl.sv
// ----------------------------------------------------------------------------
// nts_ctrl
// Ring pointers, push handling and the one-entry-per-cycle nearest scan.
// ----------------------------------------------------------------------------
`include "nearest_timestamp_sample_history_macros.svh"

module nts_ctrl #(
  parameter int HISTORY_DEPTH = 16,
  localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  nts_pkg::in_beat_t in_data,
  // result towards the output register
  output nts_pkg::res_beat_t res,
  input  logic              res_ready,
  // RAM port
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output nts_pkg::entry_t   ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  nts_pkg::entry_t   ram_rdata
);

  localparam logic [AW-1:0]    LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HISTORY_DEPTH);

  nts_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]    oldest_r, oldest_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             pend_r, pend_nxt;
  logic             first_r, first_nxt;
  logic             found_r, found_nxt;
  logic [31:0]      q_time_r, q_time_nxt;
  logic [31:0]      best_dist_r, best_dist_nxt;
  nts_pkg::entry_t  best_r, best_nxt;

  logic        in_acc;
  logic        qry_acc;
  logic        in_result;
  logic        full;
  logic        empty;
  logic [31:0] abs_diff;

  // ring increment with wrap at the history depth
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  // absolute distance; the magnitude of a 33-bit difference of two u32 fits 32 bits
  always_comb begin
    if (q_time_r >= ram_rdata.ts) begin
      abs_diff = q_time_r - ram_rdata.ts;
    end else begin
      abs_diff = ram_rdata.ts - q_time_r;
    end
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    scan_ptr_nxt  = scan_ptr_r;
    remain_nxt    = remain_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    q_time_nxt    = q_time_r;
    best_dist_nxt = best_dist_r;
    best_nxt      = best_r;

    full      = (count_r == FULL_CNT);
    empty     = (count_r == '0);
    in_ready  = (state_r == nts_pkg::ST_IDLE);
    in_acc    = in_valid && in_ready;
    qry_acc   = in_acc && (in_data.req_type == nts_pkg::REQ_QUERY);
    in_result = (state_r == nts_pkg::ST_RESULT);

    // push writes straight from the input beat; no scan runs while idle
    ram_we            = in_acc && (in_data.req_type == nts_pkg::REQ_PUSH);
    ram_waddr         = wr_ptr_r;
    ram_wdata.ts      = in_data.sample_time;
    ram_wdata.yaw     = in_data.sample_yaw_bits;
    ram_wdata.pitch   = in_data.sample_pitch_bits;
    ram_wdata.payload = in_data.sample_payload;

    ram_re    = (state_r == nts_pkg::ST_SCAN);
    ram_raddr = scan_ptr_r;
    pend_nxt  = ram_re;

    unique case (state_r)
      nts_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == nts_pkg::REQ_PUSH) begin
            wr_ptr_nxt = next_slot(wr_ptr_r);
            if (full) begin
              oldest_nxt = next_slot(oldest_r);
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            q_time_nxt = in_data.query_time;
            if (empty) begin
              found_nxt = 1'b0;
              best_nxt  = '0;
              state_nxt = nts_pkg::ST_RESULT;
            end else begin
              found_nxt    = 1'b1;
              first_nxt    = 1'b1;
              scan_ptr_nxt = oldest_r;
              remain_nxt   = count_r;
              state_nxt    = nts_pkg::ST_SCAN;
            end
          end
        end
      end
      nts_pkg::ST_SCAN: begin
        scan_ptr_nxt = next_slot(scan_ptr_r);
        remain_nxt   = remain_r - CNT_W'(1);
        if (remain_r == CNT_W'(1)) begin
          state_nxt = nts_pkg::ST_DRAIN;
        end
      end
      nts_pkg::ST_DRAIN: begin
        state_nxt = nts_pkg::ST_RESULT;
      end
      nts_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_nxt = nts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nts_pkg::ST_IDLE;
      end
    endcase

    // compare the entry read last cycle; strict less keeps the oldest on a tie
    if (pend_r && (first_r || (abs_diff < best_dist_r))) begin
      first_nxt     = 1'b0;
      best_dist_nxt = abs_diff;
      best_nxt      = ram_rdata;
    end

    res.valid                 = in_result;
    res.data.found            = found_r;
    res.data.match_time       = best_r.ts;
    res.data.match_yaw_bits   = best_r.yaw;
    res.data.match_pitch_bits = best_r.pitch;
    res.data.match_payload    = best_r.payload;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nts_pkg::ST_IDLE;
      oldest_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
      pend_r   <= 1'b0;
      first_r  <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      first_r  <= first_nxt;
      found_r  <= found_nxt;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    scan_ptr_r  <= scan_ptr_nxt;
    remain_r    <= remain_nxt;
    q_time_r    <= q_time_nxt;
    best_dist_r <= best_dist_nxt;
    best_r      <= best_nxt;
  end

  // checks
  `NTS_ASSERT_NOW(a_cnt_bound, 1'b1, count_r <= FULL_CNT, "entry count above depth")
  `NTS_ASSERT_NOW(a_ring_ptrs, empty || full, wr_ptr_r == oldest_r, "ring pointers out of step")
  `NTS_ASSERT_NEXT(a_empty_query, qry_acc && empty, in_result && !found_r, "bad empty query")
  `NTS_ASSERT_NEXT(a_res_hold, in_result && !res_ready, in_result, "result dropped before taken")

endmodule

>>> hdl/nearest_timestamp_sample_history.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_sample_history
// Bounded history of timestamped samples with nearest-timestamp lookup.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel. req_type PUSH appends a sample (no result),
//           dropping the oldest when the history holds HISTORY_DEPTH entries.
//           req_type QUERY returns one out_* beat with the stored sample whose
//           timestamp is nearest to query_time; on a tie the oldest wins.
//   out_* : valid/ready channel, one beat per query; found=0 with zero fields
//           when the history is empty.
//   Push: a new beat can follow on the next cycle.
//   Query: the single RAM read port visits one stored entry per cycle, oldest
//   first (ST_SCAN), then ST_DRAIN waits out the registered read and ST_RESULT
//   offers the beat; an empty history goes straight to ST_RESULT. The next beat
//   is taken the cycle after the result moves into the output register.
//   Reset (rst_n low, synchronous) empties the history; no clearing pass.
//   A stalled out_ready holds the result beat; pushes are still taken while
//   it waits, a further query scans and then waits until the register frees.
// ----------------------------------------------------------------------------
module nearest_timestamp_sample_history #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nts_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nts_pkg::out_beat_t out_data
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int EW = $bits(nts_pkg::entry_t);

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  nts_pkg::entry_t    ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  nts_pkg::entry_t    ram_rdata;
  nts_pkg::res_beat_t res;
  logic               res_ready;

  logic               out_valid_r, out_valid_nxt;
  nts_pkg::out_beat_t out_data_r, out_data_nxt;

  nts_ram #(
    .WIDTH (EW),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nts_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res       (res),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register: loads when empty or being drained
  always_comb begin
    res_ready     = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: nearest-timestamp sample history
// Runs a short list of directed beats and then a long random mix of pushes and
// queries through the block. Every beat taken is mirrored in a local copy of
// the history, and each result beat is checked field by field against the
// oldest prediction waiting. Both channels idle at random, with a long receiver
// hold-off and one full drain along the way.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HIST_DEPTH   = 16;
  localparam int unsigned N_RANDOM     = 1426;
  localparam int unsigned QUIET_TAIL   = 200;   // last beats sent with no idling
  localparam int unsigned HOLD_AT      = 300;   // receiver hold-off starts here
  localparam int unsigned DRAIN_AT     = 700;   // sender waits for all results here
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 40;    // > longest query latency
  localparam int unsigned TIMEOUT_NS   = 3_000_000;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned DUE_DEPTH    = 64;    // ring of predictions owed
  localparam int unsigned MAX_DIR      = 32;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  nts_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_ready;
  nts_pkg::out_beat_t out_data;

  nearest_timestamp_sample_history #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the history and the matches still owed by the block
  // --------------------------------------------------------------------------
  nts_pkg::entry_t    hist_mem [HIST_DEPTH];
  int unsigned        hist_oldest;
  int unsigned        hist_count;
  nts_pkg::out_beat_t due_buf [DUE_DEPTH];
  int unsigned        due_wr;
  int unsigned        due_rd;

  int unsigned mismatches;
  int unsigned pushes, queries, overwrites, ties, empty_queries, results_checked;
  logic [31:0] ts_cursor;
  bit          idle_on;
  bit          hold_req;

  // ring of predicted results, oldest taken first
  function automatic void due_put(nts_pkg::out_beat_t w);
    due_buf[due_wr % DUE_DEPTH] = w;
    due_wr++;
  endfunction

  function automatic nts_pkg::out_beat_t due_take();
    nts_pkg::out_beat_t r;
    r = due_buf[due_rd % DUE_DEPTH];
    due_rd++;
    return r;
  endfunction

  function automatic int unsigned due_level();
    return due_wr - due_rd;
  endfunction

  // append a sample, dropping the oldest once the history is full
  function automatic void store_sample(nts_pkg::in_beat_t b);
    nts_pkg::entry_t e;
    e.ts      = b.sample_time;
    e.yaw     = b.sample_yaw_bits;
    e.pitch   = b.sample_pitch_bits;
    e.payload = b.sample_payload;
    if (hist_count < HIST_DEPTH) begin
      hist_mem[(hist_oldest + hist_count) % HIST_DEPTH] = e;
      hist_count++;
    end else begin
      hist_mem[hist_oldest] = e;
      hist_oldest = (hist_oldest + 1) % HIST_DEPTH;
      overwrites++;
    end
  endfunction

  // nearest stored sample, oldest first so a tie keeps the older entry
  function automatic nts_pkg::out_beat_t nearest_sample(logic [31:0] qt);
    nts_pkg::out_beat_t r;
    logic [32:0]        span;
    logic [32:0]        best_span;
    int unsigned        slot;
    int unsigned        best_slot;
    bit                 tied;
    r         = '0;
    best_span = '0;
    best_slot = 0;
    tied      = 1'b0;
    if (hist_count == 0) begin
      empty_queries++;
      return r;
    end
    for (int unsigned k = 0; k < hist_count; k++) begin
      slot = (hist_oldest + k) % HIST_DEPTH;
      span = (qt >= hist_mem[slot].ts) ? {1'b0, qt - hist_mem[slot].ts}
                                       : {1'b0, hist_mem[slot].ts - qt};
      if (k == 0 || span < best_span) begin
        best_span = span;
        best_slot = slot;
        tied      = 1'b0;
      end else if (span == best_span) begin
        tied = 1'b1;
      end
    end
    if (tied) ties++;
    r.found            = 1'b1;
    r.match_time       = hist_mem[best_slot].ts;
    r.match_yaw_bits   = hist_mem[best_slot].yaw;
    r.match_pitch_bits = hist_mem[best_slot].pitch;
    r.match_payload    = hist_mem[best_slot].payload;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    nts_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_level() == 0) begin
        report_mismatch($sformatf("result beat with no query pending, time %h",
                                  out_data.match_time));
      end else begin
        want = due_take();
        results_checked++;
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found got %b want %b", out_data.found, want.found));
        if (out_data.match_time !== want.match_time)
          report_mismatch($sformatf("match_time got %h want %h",
                                    out_data.match_time, want.match_time));
        if (out_data.match_yaw_bits !== want.match_yaw_bits)
          report_mismatch($sformatf("match_yaw_bits got %h want %h",
                                    out_data.match_yaw_bits, want.match_yaw_bits));
        if (out_data.match_pitch_bits !== want.match_pitch_bits)
          report_mismatch($sformatf("match_pitch_bits got %h want %h",
                                    out_data.match_pitch_bits, want.match_pitch_bits));
        if (out_data.match_payload !== want.match_payload)
          report_mismatch($sformatf("match_payload got %h want %h",
                                    out_data.match_payload, want.match_payload));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  typedef struct {
    nts_pkg::in_beat_t  beat;
    bit                 typed;
    nts_pkg::out_beat_t want;
  } dir_row_t;

  dir_row_t    dir_rows [MAX_DIR];
  int unsigned n_dir;

  function automatic void add_row(dir_row_t row);
    dir_rows[n_dir] = row;
    n_dir++;
  endfunction

  function automatic void push_row(logic [31:0] ts, logic [31:0] yaw, logic [31:0] pitch,
                                   logic [31:0] payload, logic [31:0] qt);
    dir_row_t row;
    row.beat.req_type          = nts_pkg::REQ_PUSH;
    row.beat.sample_time       = ts;
    row.beat.sample_yaw_bits   = yaw;
    row.beat.sample_pitch_bits = pitch;
    row.beat.sample_payload    = payload;
    row.beat.query_time        = qt;
    row.typed                  = 1'b0;
    row.want                   = '0;
    add_row(row);
  endfunction

  // sample fields are noise on a query
  function automatic void query_row(logic [31:0] qt, bit typed, nts_pkg::out_beat_t want);
    dir_row_t row;
    row.beat.req_type          = nts_pkg::REQ_QUERY;
    row.beat.sample_time       = $urandom;
    row.beat.sample_yaw_bits   = $urandom;
    row.beat.sample_pitch_bits = $urandom;
    row.beat.sample_payload    = $urandom;
    row.beat.query_time        = qt;
    row.typed                  = typed;
    row.want                   = want;
    add_row(row);
  endfunction

  // random beat: mostly slowly rising timestamps, queries near stored samples
  function automatic nts_pkg::in_beat_t random_beat();
    nts_pkg::in_beat_t b;
    int unsigned       sa;
    int unsigned       sb;
    logic [32:0]       sum;
    b.req_type          = ($urandom_range(0, 9) < 6) ? nts_pkg::REQ_PUSH : nts_pkg::REQ_QUERY;
    b.sample_yaw_bits   = $urandom;
    b.sample_pitch_bits = $urandom;
    b.sample_payload    = $urandom;
    b.query_time        = $urandom;
    b.sample_time       = $urandom;
    if (b.req_type == nts_pkg::REQ_PUSH) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: b.sample_time = ts_cursor + $urandom_range(1, 3000);
        6:                b.sample_time = ts_cursor;           // equal timestamps
        7:                b.sample_time = $urandom;
        8: begin
          b.sample_time = $urandom_range(0, 1) ? 32'($urandom_range(0, 15))
                                               : 32'hFFFF_FFFF - $urandom_range(0, 15);
        end
        default:          b.sample_time = ts_cursor - $urandom_range(0, 500);
      endcase
      ts_cursor = b.sample_time;
    end else if (hist_count != 0) begin
      sa = (hist_oldest + $urandom_range(0, hist_count - 1)) % HIST_DEPTH;
      sb = (hist_oldest + $urandom_range(0, hist_count - 1)) % HIST_DEPTH;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b.query_time = hist_mem[sa].ts + $urandom_range(0, 4000) - 32'd2000;
        4, 5: begin
          // midpoint of two samples: an even sum gives an exact tie
          sum          = {1'b0, hist_mem[sa].ts} + {1'b0, hist_mem[sb].ts};
          b.query_time = sum[32:1];
        end
        6:          b.query_time = $urandom;
        7:          b.query_time = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        default:    b.query_time = ts_cursor + $urandom_range(0, 1000);
      endcase
    end
    return b;
  endfunction

  // offer one beat after an optional gap, then mirror it once taken
  task automatic send_beat(nts_pkg::in_beat_t b, int unsigned gap, bit typed,
                           nts_pkg::out_beat_t want);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.req_type == nts_pkg::REQ_QUERY) begin
      queries++;
      if (typed) begin
        void'(nearest_sample(b.query_time));
        due_put(want);
      end else begin
        due_put(nearest_sample(b.query_time));
      end
    end else begin
      pushes++;
      store_sample(b);
    end
  endtask

  function automatic int unsigned pick_gap();
    return (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
  endfunction

  initial begin
    nts_pkg::out_beat_t none;
    nts_pkg::out_beat_t hit_lo;
    nts_pkg::out_beat_t hit_hi;
    nts_pkg::in_beat_t  b;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    hist_oldest  = 0;
    hist_count   = 0;
    due_wr       = 0;
    due_rd       = 0;
    n_dir        = 0;
    ts_cursor    = 32'd100_000;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    none         = '0;
    hit_lo       = '{found: 1'b1, match_time: 32'h0, match_yaw_bits: 32'hFFFF_FFFF,
                     match_pitch_bits: 32'hFFFF_FFFF, match_payload: 32'hFFFF_FFFF};
    hit_hi       = '{found: 1'b1, match_time: 32'hFFFF_FFFF, match_yaw_bits: 32'h0,
                     match_pitch_bits: 32'h0, match_payload: 32'h0};

    // directed beats: empty history, timestamp extremes, tie, wrap-around
    query_row(32'h1234_5678, 1'b1, none);
    push_row(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_row(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    query_row(32'h0,         1'b1, hit_lo);
    query_row(32'hFFFF_FFFF, 1'b1, hit_hi);
    query_row(32'h7FFF_FFFF, 1'b1, hit_lo);
    query_row(32'h8000_0000, 1'b1, hit_hi);
    push_row(32'd1000, 32'h3F80_0000, 32'hBF80_0000, 32'hA5A5_A5A5, $urandom);
    push_row(32'd3000, 32'h4000_0000, 32'hC000_0000, 32'h5A5A_5A5A, $urandom);
    query_row(32'd2000, 1'b0, none);
    for (int unsigned k = 1; k <= 13; k++)
      push_row(32'd10_000 * k, $urandom, $urandom, $urandom, $urandom);
    query_row(32'h0, 1'b0, none);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned k = 0; k < n_dir; k++)
      send_beat(dir_rows[k].beat, pick_gap(), dir_rows[k].typed, dir_rows[k].want);

    // random traffic with a quiet window every fourth hundred beats
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      idle_on = (i < N_RANDOM - QUIET_TAIL) && ((i / 100) % 4 != 3);
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_level() != 0) @(posedge clk);
      end
      b = random_beat();
      send_beat(b, pick_gap(), 1'b0, none);
    end
    in_valid <= 1'b0;

    while (due_level() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d pushes (%0d dropping the oldest) and %0d queries, %0d of them tied,",
             pushes, overwrites, queries, ties);
    $display("%0d on an empty history; %0d result beats checked, %0d mismatches.",
             empty_queries, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("** nearest_timestamp_sample_history: PASSED **");
    end else begin
      $display("** nearest_timestamp_sample_history: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results still owed.", due_level());
    $display("** nearest_timestamp_sample_history: FAILED **");
    $finish;
  end

endmodule
